/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent, also during reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/epi_pkg.sv */
// shared constants for the epipolar inlier scoring block
package epi_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 32;
  localparam int COORD_FRAC     = 4;
  localparam int DIST_BITS      = 32;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_PAIR_01 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_PAIR_23 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_PAIR_45 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_PAIR_67 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_LAST    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD    = 3'd5;
endpackage

/* sv/epipolar_inlier_scoring.sv */
// stages: 6 arithmetic stages, 32 restoring divide stages and 1 output stage lie
// between the in accept edge and out_tvalid
// throughput: one item per cycle; the whole pipe holds only while out stalls
// reset: synchronous active-low rst_n clears valid bits and configuration
// registers, so items right after reset score as degenerate
module epipolar_inlier_scoring #(
  parameter int COORD_BITS = epi_pkg::COORD_BITS_DEF,
  parameter int COEF_BITS  = epi_pkg::COEF_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // first_x, first_y, second_x, second_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // distance
  output logic [epi_pkg::DIST_BITS-1:0] out_tdata,
  // is_inlier, degenerate
  output logic [1:0] out_tuser,
  input  logic cfg_wr_en,
  input  logic [epi_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [epi_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  localparam int PB   = COORD_BITS;
  localparam int CB   = COEF_BITS;
  localparam int LW   = CB + PB + 2;
  localparam int RW   = LW + PB + 2;
  localparam int R2W  = 2 * RW;
  localparam int DW   = 2 * LW + 1;
  localparam int QW   = epi_pkg::DIST_BITS;
  localparam int XW   = (R2W > DW + QW) ? R2W : DW + QW;
  localparam int NS   = QW;
  localparam int LH   = (LW + 1) / 2;
  localparam int LHI  = LW - LH;
  localparam int HHW  = 2 * LHI;
  localparam int HLW  = LHI + LH;
  localparam int LLW  = 2 * LH;
  localparam int SQW  = 2 * LW;
  localparam int RH   = (RW + 1) / 2;
  localparam int RHI  = RW - RH;
  localparam int RHHW = 2 * RHI;
  localparam int RHLW = RHI + RH;
  localparam int RLLW = 2 * RH;

  logic [epi_pkg::CFG_DATA_BITS-1:0] pair_r [4];
  logic [31:0] last_r, thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) pair_r[i] <= '0;
      last_r <= '0;
      thr_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        epi_pkg::REG_COEF_PAIR_01: pair_r[0] <= cfg_wdata;
        epi_pkg::REG_COEF_PAIR_23: pair_r[1] <= cfg_wdata;
        epi_pkg::REG_COEF_PAIR_45: pair_r[2] <= cfg_wdata;
        epi_pkg::REG_COEF_PAIR_67: pair_r[3] <= cfg_wdata;
        epi_pkg::REG_COEF_LAST:    last_r    <= cfg_wdata[31:0];
        epi_pkg::REG_THRESHOLD:    thr_r     <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  logic signed [CB-1:0] f [9];
  always_comb begin
    for (int k = 0; k < 8; k++) f[k] = $signed(pair_r[k/2][32*(k%2) +: CB]);
    f[8] = $signed(last_r[CB-1:0]);
  end

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  function automatic logic [LW-1:0] mag(logic signed [LW-1:0] v);
    return v[LW-1] ? unsigned'(-v) : unsigned'(v);
  endfunction

  // stage 1: epipolar lines
  logic signed [PB-1:0] x1, y1, x2, y2;
  assign x1 = $signed(in_tdata[PB-1:0]);
  assign y1 = $signed(in_tdata[2*PB-1:PB]);
  assign x2 = $signed(in_tdata[3*PB-1:2*PB]);
  assign y2 = $signed(in_tdata[4*PB-1:3*PB]);

  logic signed [LW-1:0] l1_nxt [3], l2_nxt [3], l1_r [3], l2_r [3];
  logic signed [PB-1:0] x2_r, y2_r;
  logic v1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l2_nxt[i] = LW'(f[3*i]) * LW'(x1) + LW'(f[3*i+1]) * LW'(y1)
                + (LW'(f[3*i+2]) <<< epi_pkg::COORD_FRAC);
      l1_nxt[i] = LW'(f[i]) * LW'(x2) + LW'(f[3+i]) * LW'(y2)
                + (LW'(f[6+i]) <<< epi_pkg::COORD_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r <= l1_nxt;
      l2_r <= l2_nxt;
      x2_r <= x2;
      y2_r <= y2;
    end
  end

  // stage 2: residual terms, normal magnitudes, degenerate flag
  logic signed [RW-1:0] t_r [3];
  logic [LW-1:0] m_r [4];
  logic dg2_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r[0] <= RW'(x2_r) * RW'(l2_r[0]);
      t_r[1] <= RW'(y2_r) * RW'(l2_r[1]);
      t_r[2] <= RW'(l2_r[2]) <<< epi_pkg::COORD_FRAC;
      m_r[0] <= mag(l1_r[0]);
      m_r[1] <= mag(l1_r[1]);
      m_r[2] <= mag(l2_r[0]);
      m_r[3] <= mag(l2_r[1]);
      dg2_r  <= (l1_r[0] == '0 && l1_r[1] == '0) || (l2_r[0] == '0 && l2_r[1] == '0);
    end
  end

  // stage 3: residual sum, partial products of the squared normals
  logic signed [RW-1:0] r_r;
  logic [HHW-1:0] hh_r [4];
  logic [HLW-1:0] hl_r [4];
  logic [LLW-1:0] ll_r [4];
  logic dg3_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r_r   <= t_r[0] + t_r[1] + t_r[2];
      for (int i = 0; i < 4; i++) begin
        hh_r[i] <= HHW'(m_r[i][LW-1:LH]) * HHW'(m_r[i][LW-1:LH]);
        hl_r[i] <= HLW'(m_r[i][LW-1:LH]) * HLW'(m_r[i][LH-1:0]);
        ll_r[i] <= LLW'(m_r[i][LH-1:0]) * LLW'(m_r[i][LH-1:0]);
      end
      dg3_r <= dg2_r;
    end
  end

  // stage 4: squared normal components, residual magnitude
  logic [SQW-1:0] sq_r [4];
  logic [RW-1:0] rm_r;
  logic dg4_r, v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= (SQW'(hh_r[i]) << (2*LH)) + (SQW'(hl_r[i]) << (LH+1)) + SQW'(ll_r[i]);
      end
      rm_r  <= r_r[RW-1] ? unsigned'(-r_r) : unsigned'(r_r);
      dg4_r <= dg3_r;
    end
  end

  // stage 5: normal sums, partial products of the squared residual
  logic [DW-1:0] d1_r, d2_r;
  logic [RHHW-1:0] rhh_r;
  logic [RHLW-1:0] rhl_r;
  logic [RLLW-1:0] rll_r;
  logic dg5_r, v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r  <= DW'(sq_r[0]) + DW'(sq_r[1]);
      d2_r  <= DW'(sq_r[2]) + DW'(sq_r[3]);
      rhh_r <= RHHW'(rm_r[RW-1:RH]) * RHHW'(rm_r[RW-1:RH]);
      rhl_r <= RHLW'(rm_r[RW-1:RH]) * RHLW'(rm_r[RH-1:0]);
      rll_r <= RLLW'(rm_r[RH-1:0]) * RLLW'(rm_r[RH-1:0]);
      dg5_r <= dg4_r;
    end
  end

  // stage 6: squared residual, then the divide pipe
  logic [XW-1:0] ra_r [NS+1], rb_r [NS+1];
  logic [DW-1:0] da_r [NS+1], db_r [NS+1];
  logic [QW-1:0] qa_r [NS+1], qb_r [NS+1];
  logic sa_r [NS+1], sb_r [NS+1], dg_r [NS+1], v_r [NS+1];
  logic [XW-1:0] r2;

  assign r2 = (XW'(rhh_r) << (2*RH)) + (XW'(rhl_r) << (RH+1)) + XW'(rll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (adv) v_r[0] <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ra_r[0] <= r2;
      rb_r[0] <= r2;
      da_r[0] <= d1_r;
      db_r[0] <= d2_r;
      qa_r[0] <= '0;
      qb_r[0] <= '0;
      sa_r[0] <= 1'b0;
      sb_r[0] <= 1'b0;
      dg_r[0] <= dg5_r;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int K = NS - 1 - s;
    logic [XW-1:0] sha, shb;
    logic ga, gb, sat_a, sat_b;
    assign sha = XW'(da_r[s]) << K;
    assign shb = XW'(db_r[s]) << K;
    assign ga  = ra_r[s] >= sha;
    assign gb  = rb_r[s] >= shb;
    if (s == 0) begin : g_sat
      assign sat_a = ra_r[s] >= (XW'(da_r[s]) << QW);
      assign sat_b = rb_r[s] >= (XW'(db_r[s]) << QW);
    end else begin : g_pass
      assign sat_a = sa_r[s];
      assign sat_b = sb_r[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else if (adv) v_r[s+1] <= v_r[s];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ra_r[s+1] <= ga ? ra_r[s] - sha : ra_r[s];
        rb_r[s+1] <= gb ? rb_r[s] - shb : rb_r[s];
        qa_r[s+1] <= qa_r[s] | (QW'(ga) << K);
        qb_r[s+1] <= qb_r[s] | (QW'(gb) << K);
        da_r[s+1] <= da_r[s];
        db_r[s+1] <= db_r[s];
        sa_r[s+1] <= sat_a;
        sb_r[s+1] <= sat_b;
        dg_r[s+1] <= dg_r[s];
      end
    end
  end

  // output stage
  logic [QW:0] qsum;
  logic [QW-1:0] dist_nxt, dist_r;
  logic inl_r, dgo_r, vo_r;

  assign qsum = {1'b0, qa_r[NS]} + {1'b0, qb_r[NS]};
  always_comb begin
    if (dg_r[NS] || sa_r[NS] || sb_r[NS] || qsum[QW]) dist_nxt = epi_pkg::DIST_MAX;
    else dist_nxt = qsum[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (adv) vo_r <= v_r[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_nxt;
      inl_r  <= !dg_r[NS] && (dist_nxt < thr_r);
      dgo_r  <= dg_r[NS];
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = dist_r;
  assign out_tuser  = {dgo_r, inl_r};
endmodule

/* sv/epi_checker.sv */
// port-level checks for the epipolar inlier scoring block
`include "assert_macros.svh"

module epi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [epi_pkg::DIST_BITS-1:0] out_tdata,
  input logic [1:0] out_tuser
);
  logic degen_o, inl_o, dist_sat, stall;
  logic [epi_pkg::DIST_BITS+1:0] out_word;

  assign degen_o  = out_tuser[1];
  assign inl_o    = out_tuser[0];
  assign dist_sat = out_tdata == epi_pkg::DIST_MAX;
  assign stall    = out_tvalid && !out_tready;
  assign out_word = {out_tuser, out_tdata};

  `ASSERT_IMP(a_degen_sat, out_tvalid && degen_o, dist_sat && !inl_o, "degenerate not saturated")
  `ASSERT_IMP(a_inlier_below_max, out_tvalid && inl_o, !dist_sat, "inlier at saturated distance")
  `ASSERT_NEXT(a_out_hold, stall, out_tvalid && $stable(out_word), "stalled item changed")
  `ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid && in_tready, "pipe not empty after reset")
endmodule

bind epipolar_inlier_scoring epi_checker u_epi_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
